[design/rph_pkg.sv]
// Shared types and status codes for the ray/plane hit test pipeline.
package rph_pkg;

	localparam logic [1:0] ST_SUCCESS   = 2'd0;
	localparam logic [1:0] ST_PARALLEL  = 2'd1;
	localparam logic [1:0] ST_OTHER_WAY = 2'd2;
	localparam logic [1:0] ST_BEHIND    = 2'd3;

	localparam int NUM_W   = 51;
	localparam int DEN_W   = 50;
	localparam int QUO_W   = 31;
	localparam int REM_W   = NUM_W + 16;
	localparam int TRIAL_W = DEN_W + QUO_W;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec3_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [NUM_W-1:0] nmag;
		logic [DEN_W-1:0] dmag;
		vec3_t            s;
		vec3_t            d;
	} div_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] t;
		vec3_t       s;
		vec3_t       d;
	} scale_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic       sat;
		vec3_t      s;
		vec3_t      d;
	} div_meta_t;

endpackage

[design/rph_front.sv]
// Dot products, classification and magnitudes (two stages).
module rph_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [30:0]          eps,
	input  rph_pkg::vec3_t       s,
	input  rph_pkg::vec3_t       d,
	input  rph_pkg::vec3_t       n,
	input  logic signed [31:0]   off,
	output logic                 valid_s2,
	output rph_pkg::div_in_t     item_s2
);
	logic signed [47:0] pnd_s1 [3];
	logic signed [47:0] psn_s1 [3];
	logic signed [47:0] pnn_s1 [3];
	logic signed [31:0] off_s1;
	rph_pkg::vec3_t     s_s1, d_s1;
	logic               valid_s1;

	logic signed [63:0] pnd [3];
	logic signed [63:0] psn [3];
	logic signed [63:0] pnn [3];

	assign pnd[0] = n.x * d.x;
	assign pnd[1] = n.y * d.y;
	assign pnd[2] = n.z * d.z;
	assign psn[0] = s.x * n.x;
	assign psn[1] = s.y * n.y;
	assign psn[2] = s.z * n.z;
	assign pnn[0] = n.x * n.x;
	assign pnn[1] = n.y * n.y;
	assign pnn[2] = n.z * n.z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// floor to Q16.16 is the upper bits of the exact product
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pnd_s1[i] <= pnd[i][63:16];
				psn_s1[i] <= psn[i][63:16];
				pnn_s1[i] <= pnn[i][63:16];
			end
			off_s1 <= off;
			s_s1   <= s;
			d_s1   <= d;
		end
	end

	logic signed [49:0] denom, nn;
	logic signed [50:0] numer;
	logic signed [51:0] behind;
	logic [49:0]        dmag;
	logic [50:0]        nmag;
	logic [1:0]         status;

	always_comb begin
		denom  = 50'(pnd_s1[0]) + 50'(pnd_s1[1]) + 50'(pnd_s1[2]);
		nn     = 50'(pnn_s1[0]) + 50'(pnn_s1[1]) + 50'(pnn_s1[2]);
		numer  = 51'(psn_s1[0]) + 51'(psn_s1[1]) + 51'(psn_s1[2]) - 51'(off_s1);
		behind = 52'(numer) - 52'(nn);
		dmag   = denom[49] ? 50'(-denom) : 50'(denom);
		nmag   = numer[50] ? 51'(-numer) : 51'(numer);
		if (denom == '0 || dmag < 50'(eps))
			status = rph_pkg::ST_PARALLEL;
		else if (numer != '0 && ((!numer[50]) != denom[49]))
			status = rph_pkg::ST_OTHER_WAY;
		else if (behind[51])
			status = rph_pkg::ST_BEHIND;
		else
			status = rph_pkg::ST_SUCCESS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2.status <= status;
			item_s2.nmag   <= nmag;
			item_s2.dmag   <= dmag;
			item_s2.s      <= s_s1;
			item_s2.d      <= d_s1;
		end
	end
endmodule

[design/rph_div.sv]
// Pipelined restoring divider: one quotient bit per stage, with saturation flag.
module rph_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  rph_pkg::div_in_t     item,
	output logic                 out_valid,
	output rph_pkg::scale_in_t   out_item
);
	localparam int N = rph_pkg::QUO_W;

	logic [rph_pkg::REM_W-1:0] rem_s [N+1];
	logic [rph_pkg::DEN_W-1:0] den_s [N+1];
	logic [N-1:0]              q_s   [N+1];
	rph_pkg::div_meta_t        meta_s[N+1];
	logic [N:0]                valid_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s[0] <= 1'b0;
		else if (en)
			valid_s[0] <= in_valid;
	end

	// quotient >= 2^31 exactly when nmag >= dmag * 2^15
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]         <= {item.nmag, 16'b0};
			den_s[0]         <= item.dmag;
			q_s[0]           <= '0;
			meta_s[0].status <= item.status;
			meta_s[0].sat    <= {14'b0, item.nmag} >= {item.dmag, 15'b0};
			meta_s[0].s      <= item.s;
			meta_s[0].d      <= item.d;
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_st
		localparam int B = N - k;
		logic [rph_pkg::TRIAL_W-1:0] dsh, r_ext;
		logic                        ge;

		assign dsh   = {{N{1'b0}}, den_s[k-1]} << B;
		assign r_ext = {{(rph_pkg::TRIAL_W - rph_pkg::REM_W){1'b0}}, rem_s[k-1]};
		assign ge    = r_ext >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[k] <= 1'b0;
			else if (en)
				valid_s[k] <= valid_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? rph_pkg::REM_W'(r_ext - dsh) : rem_s[k-1];
				den_s[k]  <= den_s[k-1];
				q_s[k]    <= q_s[k-1] | (N'(ge) << B);
				meta_s[k] <= meta_s[k-1];
			end
		end
	end

	assign out_valid       = valid_s[N];
	assign out_item.status = meta_s[N].status;
	assign out_item.t      = meta_s[N].sat ? 32'h7FFF_FFFF : {1'b0, q_s[N]};
	assign out_item.s      = meta_s[N].s;
	assign out_item.d      = meta_s[N].d;
endmodule

[design/rph_scale.sv]
// Impact point: dir * t, add start, saturate, gate by status (two stages).
module rph_scale (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  rph_pkg::scale_in_t   item,
	output logic                 valid_s2,
	output logic [1:0]           status_s2,
	output rph_pkg::vec3_t       imp_s2,
	output logic signed [31:0]   dist_s2
);
	logic signed [48:0] p_s1 [3];
	rph_pkg::vec3_t     s_s1;
	logic [1:0]         status_s1;
	logic [31:0]        t_s1;
	logic               valid_s1;

	logic signed [32:0] ts;
	logic signed [64:0] p [3];

	assign ts   = $signed({1'b0, item.t});
	assign p[0] = item.d.x * ts;
	assign p[1] = item.d.y * ts;
	assign p[2] = item.d.z * ts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				p_s1[i] <= p[i][64:16];
			s_s1      <= item.s;
			status_s1 <= item.status;
			t_s1      <= item.t;
		end
	end

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic signed [31:0] r;
		if (v > 50'sh7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -50'sh8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	logic ok;
	assign ok = status_s1 == rph_pkg::ST_SUCCESS;

	always_ff @(posedge clk) begin
		if (en) begin
			status_s2 <= status_s1;
			imp_s2.x  <= ok ? sat32(50'(s_s1.x) + 50'(p_s1[0])) : '0;
			imp_s2.y  <= ok ? sat32(50'(s_s1.y) + 50'(p_s1[1])) : '0;
			imp_s2.z  <= ok ? sat32(50'(s_s1.z) + 50'(p_s1[2])) : '0;
			dist_s2   <= ok ? $signed(t_s1) : '0;
		end
	end
endmodule

[design/ray_plane_hit_test.sv]
// Pipeline from input accept to result: dot/classify stages, then divide stages, then impact stages.
// Throughput: one item per cycle; the whole pipeline advances unless a result is stalled.
// Divider: restoring, one quotient bit per stage over 31 stages plus a setup stage.
// Reset (arst_n low, async): all valid bits clear, epsilon register returns to 1.
// Top level of the ray/plane hit test.
module ray_plane_hit_test (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [30:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic signed [31:0] normal_x,
	input  logic signed [31:0] normal_y,
	input  logic signed [31:0] normal_z,
	input  logic signed [31:0] plane_offset,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         hit_status,
	output logic signed [31:0] impact_x,
	output logic signed [31:0] impact_y,
	output logic signed [31:0] impact_z,
	output logic signed [31:0] hit_distance
);
	logic [30:0] eps_q;
	logic        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			eps_q <= 31'd1;
		else if (cfg_wr_en)
			eps_q <= cfg_wr_data;
	end

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	rph_pkg::vec3_t     s, d, n, imp;
	rph_pkg::div_in_t   div_item;
	rph_pkg::scale_in_t sc_item;
	logic               div_valid, sc_valid;

	assign s = '{x: start_x, y: start_y, z: start_z};
	assign d = '{x: dir_x, y: dir_y, z: dir_z};
	assign n = '{x: normal_x, y: normal_y, z: normal_z};

	rph_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.eps      (eps_q),
		.s        (s),
		.d        (d),
		.n        (n),
		.off      (plane_offset),
		.valid_s2 (div_valid),
		.item_s2  (div_item)
	);

	rph_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.item      (div_item),
		.out_valid (sc_valid),
		.out_item  (sc_item)
	);

	rph_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sc_valid),
		.item      (sc_item),
		.valid_s2  (out_valid),
		.status_s2 (hit_status),
		.imp_s2    (imp),
		.dist_s2   (hit_distance)
	);

	assign impact_x = imp.x;
	assign impact_y = imp.y;
	assign impact_z = imp.z;
endmodule

[design/rph_checker.sv]
// Port-level checks for the ray/plane hit test, bound to the top level.
module rph_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         hit_status,
	input logic signed [31:0] impact_x,
	input logic signed [31:0] impact_y,
	input logic signed [31:0] impact_z,
	input logic signed [31:0] hit_distance
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit_distance))
		else $error("result dropped or changed under stall");

	a_zero_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_status != rph_pkg::ST_SUCCESS |->
		impact_x == 0 && impact_y == 0 && impact_z == 0 && hit_distance == 0)
		else $error("non-success item carries nonzero result");

	a_dist_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_status == rph_pkg::ST_SUCCESS |-> !hit_distance[31])
		else $error("negative distance on success");

	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");
endmodule

bind ray_plane_hit_test rph_checker u_rph_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the ray/plane hit test pipeline.
`timescale 1ns / 1ps
module testbench;

	typedef struct {
		logic signed [31:0] v [10];
	} ray_t;

	typedef struct {
		logic [1:0]         status;
		logic signed [31:0] ix, iy, iz, distance;
	} hit_t;

	typedef struct {
		logic signed [31:0] v [10];
		bit                 known;
		hit_t               res;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic [30:0] cfg_wr_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] start_x = 0, start_y = 0, start_z = 0;
	logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
	logic signed [31:0] normal_x = 0, normal_y = 0, normal_z = 0, plane_offset = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] hit_status;
	logic signed [31:0] impact_x, impact_y, impact_z, hit_distance;

	always #5 clk = ~clk;

	ray_plane_hit_test u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.plane_offset(plane_offset),
		.out_valid(out_valid), .out_stall(out_stall), .hit_status(hit_status),
		.impact_x(impact_x), .impact_y(impact_y), .impact_z(impact_z),
		.hit_distance(hit_distance)
	);

	logic [30:0] epsilon;
	hit_t pending_hits [$];
	int errors = 0;
	int sent = 0, checked = 0;
	int status_seen [4];
	int idle_cycles = 0;
	bit hold_off = 0;
	bit rx_random = 0;
	bit tx_random = 0;

	// floored Q16.16 product
	function automatic logic signed [127:0] fxmul(logic signed [127:0] a,
			logic signed [127:0] b);
		return (a * b) >>> 16;
	endfunction

	function automatic logic signed [127:0] clamp32(logic signed [127:0] v);
		if (v > 128'sd2147483647)
			return 128'sd2147483647;
		if (v < -128'sd2147483648)
			return -128'sd2147483648;
		return v;
	endfunction

	function automatic hit_t predict_hit(ray_t r, logic [30:0] eps);
		logic signed [127:0] s [3], d [3], n [3];
		logic signed [127:0] den, num, nn, dmag, nmag, t, q;
		hit_t h;
		h = '{rph_pkg::ST_SUCCESS, 0, 0, 0, 0};
		for (int i = 0; i < 3; i++) begin
			s[i] = r.v[i];
			d[i] = r.v[3+i];
			n[i] = r.v[6+i];
		end
		den = fxmul(n[0], d[0]) + fxmul(n[1], d[1]) + fxmul(n[2], d[2]);
		num = fxmul(s[0], n[0]) + fxmul(s[1], n[1]) + fxmul(s[2], n[2])
			- 128'(r.v[9]);
		nn = fxmul(n[0], n[0]) + fxmul(n[1], n[1]) + fxmul(n[2], n[2]);
		dmag = den < 0 ? -den : den;
		nmag = num < 0 ? -num : num;
		if (den == 0 || dmag < 128'(eps))
			h.status = rph_pkg::ST_PARALLEL;
		else if (num != 0 && ((-num < 0) != (den < 0)))
			h.status = rph_pkg::ST_OTHER_WAY;
		else if (num - nn < 0)
			h.status = rph_pkg::ST_BEHIND;
		else begin
			q = (nmag <<< 16) / dmag;
			t = q > 128'sd2147483647 ? 128'sd2147483647 : q;
			h.distance = t[31:0];
			h.ix = 32'(clamp32(s[0] + fxmul(d[0], t)));
			h.iy = 32'(clamp32(s[1] + fxmul(d[1], t)));
			h.iz = 32'(clamp32(s[2] + fxmul(d[2], t)));
		end
		return h;
	endfunction

	function automatic logic signed [31:0] rand_field();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
			2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: return $signed($urandom_range(0, 24'h3FFFFF)) - 32'sh200000;
		endcase
	endfunction

	// mostly hitting geometry: normal and direction roughly opposed, start in front
	function automatic ray_t rand_ray();
		ray_t r;
		int k;
		k = $urandom_range(0, 9);
		for (int i = 0; i < 10; i++)
			r.v[i] = rand_field();
		if (k < 6) begin
			for (int i = 0; i < 3; i++) begin
				r.v[6+i] = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
				r.v[3+i] = -r.v[6+i] + $signed($urandom_range(0, 32'h1FFF)) - 32'sh1000;
				r.v[i] = $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000;
			end
			r.v[9] = $signed($urandom_range(0, 32'h7FFFFF)) - 32'sh600000;
		end
		return r;
	endfunction

	task automatic send_ray(ray_t r, bit known, hit_t res);
		hit_t p;
		p = predict_hit(r, epsilon);
		if (known && p != res) begin
			$display("%0t table row disagrees with predictor: table %p predicted %p",
				$time, res, p);
			errors++;
		end
		if (tx_random)
			while ($urandom_range(0, 3) == 0) begin
				in_valid <= 0;
				@(posedge clk);
			end
		in_valid <= 1;
		{start_x, start_y, start_z, dir_x, dir_y, dir_z} <=
			{r.v[0], r.v[1], r.v[2], r.v[3], r.v[4], r.v[5]};
		{normal_x, normal_y, normal_z, plane_offset} <= {r.v[6], r.v[7], r.v[8], r.v[9]};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_hits.push_back(known ? res : p);
		sent++;
	endtask

	task automatic drain_and_config(logic [30:0] value);
		in_valid <= 0;
		@(posedge clk);
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= value;
		epsilon = value;
		@(posedge clk);
		cfg_wr_en <= 0;
	endtask

	// receiver stall pattern plus one long hold-off
	always @(posedge clk) begin
		if (hold_off)
			out_stall <= 1;
		else if (rx_random)
			out_stall <= ($urandom_range(0, 7) < 3);
		else
			out_stall <= 0;
	end

	always @(posedge clk) begin
		hit_t e;
		if (arst_n && out_valid && !out_stall) begin
			checked++;
			status_seen[hit_status]++;
			if (pending_hits.size() == 0) begin
				$display("%0t unexpected result status %0d", $time, hit_status);
				errors++;
			end else begin
				e = pending_hits.pop_front();
				if (hit_status !== e.status || impact_x !== e.ix || impact_y !== e.iy ||
						impact_z !== e.iz || hit_distance !== e.distance) begin
					$display("%0t mismatch: expected st=%0d x=%h y=%h z=%h t=%h",
						$time, e.status, e.ix, e.iy, e.iz, e.distance);
					$display("%0t            actual st=%0d x=%h y=%h z=%h t=%h",
						$time, hit_status, impact_x, impact_y, impact_z, hit_distance);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("watchdog expired, %0d results outstanding", pending_hits.size());
			$display("ray_plane_hit_test test failed");
			$finish;
		end
	end

	initial begin
		row_t rows [$];
		row_t rw;
		ray_t r;
		hit_t zero_hit;
		logic [30:0] eps_list [6];
		zero_hit = '{rph_pkg::ST_PARALLEL, 0, 0, 0, 0};
		eps_list = '{31'd0, 31'h7FFFFFFF, 31'h10000, 31'd1, 31'h100, 31'h400};
		epsilon = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// all zero: parallel at reset epsilon
		rw.v = '{default: 0}; rw.known = 1; rw.res = zero_hit; rows.push_back(rw);
		// zero normal, max extremes elsewhere: still parallel
		rw.v = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
			32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 32'sh7FFFFFFF};
		rows.push_back(rw);
		rw.known = 0;
		// hit: start z=5, dir -z, plane z=0 with normal +z
		rw.v = '{0, 0, 32'sh50000, 0, 0, -32'sh10000, 0, 0, 32'sh10000, 0};
		rows.push_back(rw);
		// other way
		rw.v = '{0, 0, 32'sh50000, 0, 0, 32'sh10000, 0, 0, 32'sh10000, 0};
		rows.push_back(rw);
		// behind
		rw.v = '{0, 0, 32'sh8000, 0, 0, -32'sh10000, 0, 0, 32'sh10000, 0};
		rows.push_back(rw);
		// huge t saturates, impact saturates
		rw.v = '{32'sh7FFF0000, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, -32'sh1, 0, 0,
			32'sh10000, 32'sh80000000};
		rows.push_back(rw);
		// numerator zero
		rw.v = '{0, 0, 0, 0, 0, -32'sh10000, 0, 0, 32'sh10000, 0};
		rows.push_back(rw);
		// extremes everywhere
		rw.v = '{default: 32'sh80000000}; rows.push_back(rw);
		rw.v = '{default: 32'sh7FFFFFFF}; rows.push_back(rw);
		rw.v = '{default: -32'sh1}; rows.push_back(rw);
		rw.v = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
			32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
			32'sh80000000, 32'sh7FFFFFFF};
		rows.push_back(rw);
		// tiny denominator (1 lsb): parallel only above epsilon 1
		rw.v = '{0, 0, 32'sh10000, 0, 0, -32'sh1, 0, 0, 32'sh10000, 0};
		rows.push_back(rw);
		foreach (rows[i]) begin
			r.v = rows[i].v;
			send_ray(r, rows[i].known, rows[i].res);
		end

		foreach (eps_list[k]) begin
			drain_and_config(eps_list[k]);
			foreach (rows[i]) begin
				r.v = rows[i].v;
				send_ray(r, 0, zero_hit);
			end
			rx_random = (k % 2 == 1);
			tx_random = (k >= 2);
			for (int n = 0; n < 210; n++) begin
				r = rand_ray();
				send_ray(r, 0, zero_hit);
			end
			if (k == 3) begin
				hold_off = 1;
				fork
					begin
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
					begin
						for (int n = 0; n < 60; n++) begin
							r = rand_ray();
							send_ray(r, 0, zero_hit);
						end
					end
				join
			end
		end

		in_valid <= 0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("sent %0d rays, checked %0d results over six epsilon settings", sent,
			checked);
		$display("status counts: hit %0d parallel %0d other-way %0d behind %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (errors == 0)
			$display("ray_plane_hit_test test passed");
		else
			$display("ray_plane_hit_test test failed");
		$finish;
	end

endmodule
